// File: hdl/dpfs_pkg.sv
// Shared types and constants of the day phase fraction scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dpfs_pkg;

	// Field widths
	localparam int unsigned MinW     = 11;
	localparam int unsigned PhaseW   = 2;
	localparam int unsigned ProgW    = 8;
	localparam int unsigned ElapsedW = 12;
	localparam int unsigned DivW     = 20;
	localparam int unsigned QuotW    = 9;
	localparam int unsigned IdxW     = 3;
	localparam int unsigned PhaseCount = 4;

	// Day constants
	localparam logic [MinW-1:0]     MinutesPerDay = 11'd1440;
	localparam logic [ElapsedW-1:0] DayWide       = 12'd1440;
	localparam logic [ProgW-1:0]    ProgressMax   = 8'd255;
	localparam logic [PhaseW-1:0]   LastSlot      = 2'd3;

	// Reset starts
	localparam logic [MinW-1:0] NightReset   = 11'd0;
	localparam logic [MinW-1:0] SunriseReset = 11'd360;
	localparam logic [MinW-1:0] DayReset     = 11'd480;
	localparam logic [MinW-1:0] SunsetReset  = 11'd1140;

	// Reset lengths per phase
	localparam logic [MinW-1:0] NightLenReset   = 11'd360;
	localparam logic [MinW-1:0] SunriseLenReset = 11'd120;
	localparam logic [MinW-1:0] DayLenReset     = 11'd660;
	localparam logic [MinW-1:0] SunsetLenReset  = 11'd300;

	// Register indexes
	typedef enum logic [IdxW-1:0] {
		REG_NIGHT_START   = 3'd0,
		REG_SUNRISE_START = 3'd1,
		REG_DAY_START     = 3'd2,
		REG_SUNSET_START  = 3'd3,
		REG_AUTO_MODE     = 3'd4
	} dpfs_reg_t;

	// Phase codes
	typedef enum logic [PhaseW-1:0] {
		PH_NIGHT   = 2'd0,
		PH_SUNRISE = 2'd1,
		PH_DAY     = 2'd2,
		PH_SUNSET  = 2'd3
	} dpfs_phase_t;

	// Schedule held by the configuration block
	typedef struct packed {
		logic                                auto_mode;
		logic [PhaseCount-1:0][MinW-1:0]     start;
		logic [PhaseCount-1:0][PhaseW-1:0]   order;
		logic [PhaseCount-1:0][MinW-1:0]     length;
	} dpfs_sched_t;

	// Payload that walks down the divider chain
	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic              zero;
		logic [MinW-1:0]   len;
		logic [DivW-1:0]   rem;
		logic [QuotW-1:0]  quot;
	} dpfs_lane_t;

endpackage

`default_nettype wire

// File: hdl/dpfs_intf.sv
// Channel interfaces: minute ticks, phase results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface dpfs_tick_if;
	logic        valid;
	logic        ready;
	logic [10:0] minute_of_day;
	modport source (output valid, output minute_of_day, input ready);
	modport sink   (input valid, input minute_of_day, output ready);
endinterface

interface dpfs_status_if;
	logic       valid;
	logic       ready;
	logic [1:0] phase;
	logic [7:0] progress;
	logic       zero_length;
	modport source (output valid, output phase, output progress, output zero_length,
		input ready);
	modport sink   (input valid, input phase, input progress, input zero_length,
		output ready);
endinterface

interface dpfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [10:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dpfs_cfg.sv
// Configuration registers with phase order and length recompute on each write.
`timescale 1ns / 1ps
`default_nettype none

module dpfs_cfg
	import dpfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	dpfs_cfg_if.sink    cfg,
	output dpfs_sched_t sched
);

	logic [PhaseCount-1:0][MinW-1:0]   start_q;
	logic [PhaseCount-1:0][PhaseW-1:0] order_q;
	logic [PhaseCount-1:0][MinW-1:0]   length_q;
	logic                              auto_q;

	logic [PhaseCount-1:0][MinW-1:0]   start_nxt;
	logic [PhaseCount-1:0][PhaseW-1:0] order_nxt;
	logic [PhaseCount-1:0][MinW-1:0]   length_nxt;
	logic                              auto_nxt;
	logic                              hit;
	logic [PhaseW-1:0]                 latest;
	logic [MinW-1:0]                   best;

	assign cfg.ready = 1'b1;

	// Apply the write to a copy of the registers
	always_comb begin
		start_nxt = start_q;
		auto_nxt  = auto_q;
		hit       = 1'b1;
		unique case (cfg.index)
			REG_NIGHT_START:   start_nxt[PH_NIGHT]   = cfg.data;
			REG_SUNRISE_START: start_nxt[PH_SUNRISE] = cfg.data;
			REG_DAY_START:     start_nxt[PH_DAY]     = cfg.data;
			REG_SUNSET_START:  start_nxt[PH_SUNSET]  = cfg.data;
			REG_AUTO_MODE:     auto_nxt              = cfg.data[0];
			default:           hit                   = 1'b0;
		endcase
	end

	// Latest start, lowest phase wins ties; zero starts leave night latest
	always_comb begin
		latest = PH_NIGHT;
		best   = '0;
		for (int i = 0; i < PhaseCount; i++) begin
			if (start_nxt[i] > best) begin
				best   = start_nxt[i];
				latest = PhaseW'(i);
			end
		end
	end

	// Order follows the latest phase; lengths wrap mod 2048
	always_comb begin
		for (int i = 0; i < PhaseCount; i++) begin
			order_nxt[i] = latest + PhaseW'(i) + 2'd1;
			if (PhaseW'(i) == latest) begin
				length_nxt[i] = start_nxt[PhaseW'(i) + 2'd1] + MinutesPerDay - start_nxt[i];
			end else begin
				length_nxt[i] = start_nxt[PhaseW'(i) + 2'd1] - start_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= {SunsetReset, DayReset, SunriseReset, NightReset};
			order_q  <= {PH_SUNSET, PH_DAY, PH_SUNRISE, PH_NIGHT};
			length_q <= {SunsetLenReset, DayLenReset, SunriseLenReset, NightLenReset};
			auto_q   <= 1'b1;
		end else if (cfg.valid && hit) begin
			start_q  <= start_nxt;
			order_q  <= order_nxt;
			length_q <= length_nxt;
			auto_q   <= auto_nxt;
		end
	end

	assign sched.auto_mode = auto_q;
	assign sched.start     = start_q;
	assign sched.order     = order_q;
	assign sched.length    = length_q;

endmodule

`default_nettype wire

// File: hdl/dpfs_locate.sv
// Front stages: find the active phase, its elapsed minutes and the scaled dividend.
`timescale 1ns / 1ps
`default_nettype none

module dpfs_locate
	import dpfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid_i,
	input  wire logic [10:0] minute,
	input  wire dpfs_sched_t sched,
	output logic             valid_o,
	output dpfs_lane_t       lane_o
);

	logic [PhaseW-1:0]   cur;
	logic [MinW-1:0]     scur;
	logic [ElapsedW-1:0] wrapped;
	logic [ElapsedW-1:0] elapsed;

	logic                valid_s1;
	logic [PhaseW-1:0]   phase_s1;
	logic [MinW-1:0]     len_s1;
	logic [ElapsedW-1:0] elapsed_s1;
	logic                valid_s2;
	dpfs_lane_t          lane_s2;

	// Latest order slot whose start has passed, else last slot
	always_comb begin
		if (minute >= sched.start[sched.order[3]]) begin
			cur = sched.order[3];
		end else if (minute >= sched.start[sched.order[2]]) begin
			cur = sched.order[2];
		end else if (minute >= sched.start[sched.order[1]]) begin
			cur = sched.order[1];
		end else if (minute >= sched.start[sched.order[0]]) begin
			cur = sched.order[0];
		end else begin
			cur = sched.order[LastSlot];
		end
	end

	// Elapsed minutes, with midnight wrap; clamps at zero
	always_comb begin
		scur    = sched.start[cur];
		wrapped = ElapsedW'(minute) + DayWide;
		if (minute >= scur) begin
			elapsed = ElapsedW'(minute) - ElapsedW'(scur);
		end else if (wrapped >= ElapsedW'(scur)) begin
			elapsed = wrapped - ElapsedW'(scur);
		end else begin
			elapsed = '0;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	// Payload: elapsed*255 as a shift and subtract
	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1     <= cur;
			len_s1       <= sched.length[cur];
			elapsed_s1   <= elapsed;
			lane_s2.phase <= phase_s1;
			lane_s2.zero  <= (len_s1 == '0);
			lane_s2.len   <= len_s1;
			lane_s2.rem   <= {elapsed_s1, 8'd0} - DivW'(elapsed_s1);
			lane_s2.quot  <= '0;
		end
	end

	assign valid_o = valid_s2;
	assign lane_o  = lane_s2;

endmodule

`default_nettype wire

// File: hdl/dpfs_div_cell.sv
// One restoring divider cell: settles one quotient bit and passes the lane on.
`timescale 1ns / 1ps
`default_nettype none

module dpfs_div_cell
	import dpfs_pkg::*;
#(
	parameter int unsigned SHIFT = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_i,
	input  wire dpfs_lane_t lane_i,
	output logic      valid_o,
	output dpfs_lane_t lane_o
);

	logic [DivW-1:0] divisor;
	dpfs_lane_t      lane_nxt;
	logic            valid_q;
	dpfs_lane_t      lane_q;

	// Trial subtract of the shifted divisor
	always_comb begin
		divisor  = DivW'(lane_i.len) << SHIFT;
		lane_nxt = lane_i;
		if (lane_i.rem >= divisor) begin
			lane_nxt.rem         = lane_i.rem - divisor;
			lane_nxt.quot[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_nxt;
		end
	end

	assign valid_o = valid_q;
	assign lane_o  = lane_q;

endmodule

`default_nettype wire

// File: hdl/day_phase_fraction_scheduler.sv
// Top level of the day phase fraction scheduler.
//
// Channel  Role    Payload
// tick     sink    minute_of_day[10:0]
// status   source  phase[1:0], progress[7:0], zero_length
// cfg      sink    index[2:0], data[10:0]; ready is always high
//
// One tick is taken every cycle unless the chain is held; a result passes through
// two locate stages and a chain of nine divider cells (saturation bit plus 8 bits).
// The whole chain advances together: it holds while the last cell's result
// waits, and tick.ready is low only then. In manual mode ticks are taken and
// dropped. Reset loads the reset starts and their derived order and lengths.
`timescale 1ns / 1ps
`default_nettype none

module day_phase_fraction_scheduler
	import dpfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	dpfs_tick_if.sink   tick,
	dpfs_status_if.source status,
	dpfs_cfg_if.sink    cfg
);

	dpfs_sched_t              sched;
	logic                     en;
	logic [QuotW:0]           valid_c;
	dpfs_lane_t [QuotW:0]     lane_c;
	dpfs_lane_t               last;

	// Chain moves unless a finished result is stuck
	assign en         = !valid_c[QuotW] || status.ready;
	assign tick.ready = en;

	dpfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sched  (sched)
	);

	dpfs_locate u_locate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (tick.valid && sched.auto_mode),
		.minute  (tick.minute_of_day),
		.sched   (sched),
		.valid_o (valid_c[0]),
		.lane_o  (lane_c[0])
	);

	// Divider cells, quotient bit 8 (saturation) first
	for (genvar j = 0; j < QuotW; j++) begin : g_cell
		dpfs_div_cell #(
			.SHIFT (QuotW - 1 - j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_c[j]),
			.lane_i  (lane_c[j]),
			.valid_o (valid_c[j+1]),
			.lane_o  (lane_c[j+1])
		);
	end

	// Result: zero length forces 0, overflow saturates
	assign last               = lane_c[QuotW];
	assign status.valid       = valid_c[QuotW];
	assign status.phase       = last.phase;
	assign status.zero_length = last.zero;
	always_comb begin
		if (last.zero) begin
			status.progress = '0;
		end else if (last.quot[QuotW-1]) begin
			status.progress = ProgressMax;
		end else begin
			status.progress = last.quot[ProgW-1:0];
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/dpfs_status_checker.sv
// Checker for the day phase scheduler: tracks the schedule, predicts every status and compares.
`timescale 1ns / 1ps

module dpfs_status_checker
	import dpfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick_valid,
	input  wire logic              tick_ready,
	input  wire logic [MinW-1:0]   tick_minute,
	input  wire logic              status_valid,
	input  wire logic              status_ready,
	input  wire logic [PhaseW-1:0] status_phase,
	input  wire logic [ProgW-1:0]  status_progress,
	input  wire logic              status_zero,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [IdxW-1:0]   cfg_index,
	input  wire logic [MinW-1:0]   cfg_data,
	output int unsigned            errors,
	output int unsigned            outstanding
);

	typedef struct packed {
		dpfs_phase_t       phase;
		logic [ProgW-1:0]  progress;
		logic              zero_length;
	} phase_status_t;

	// Shadow copy of the schedule
	logic [MinW-1:0] start_min [PhaseCount];
	dpfs_phase_t     order     [PhaseCount];
	logic [MinW-1:0] span      [PhaseCount];
	logic            auto_on;

	phase_status_t   pending_status [$];

	// Cyclic order after the latest start, lengths wrap at 11 bits
	function automatic void rebuild_schedule();
		dpfs_phase_t     latest;
		logic [MinW-1:0] best;
		logic [PhaseW-1:0] nxt;
		latest = PH_NIGHT;
		best   = '0;
		for (int i = 0; i < PhaseCount; i++) begin
			if (start_min[i] > best) begin
				best   = start_min[i];
				latest = dpfs_phase_t'(i);
			end
		end
		order[LastSlot] = latest;
		for (int i = 0; i < LastSlot; i++) begin
			nxt      = latest + PhaseW'(i + 1);
			order[i] = dpfs_phase_t'(nxt);
		end
		span[order[LastSlot]] = start_min[order[0]] + MinutesPerDay - start_min[order[LastSlot]];
		for (int i = 0; i < LastSlot; i++) begin
			span[order[i]] = start_min[order[i + 1]] - start_min[order[i]];
		end
	endfunction

	// Register write; unknown indexes leave everything untouched
	function automatic void apply_write(logic [IdxW-1:0] idx, logic [MinW-1:0] data);
		case (idx)
			REG_NIGHT_START:   start_min[PH_NIGHT]   = data;
			REG_SUNRISE_START: start_min[PH_SUNRISE] = data;
			REG_DAY_START:     start_min[PH_DAY]     = data;
			REG_SUNSET_START:  start_min[PH_SUNSET]  = data;
			REG_AUTO_MODE:     auto_on               = data[0];
			default:           return;
		endcase
		rebuild_schedule();
	endfunction

	// Active phase and its scaled progress for one minute
	function automatic phase_status_t phase_status(logic [MinW-1:0] minute);
		dpfs_phase_t     cur;
		logic [MinW-1:0] len;
		int unsigned     elapsed, wrapped, prog;
		phase_status_t   res;
		if (minute >= start_min[order[3]])      cur = order[3];
		else if (minute >= start_min[order[2]]) cur = order[2];
		else if (minute >= start_min[order[1]]) cur = order[1];
		else if (minute >= start_min[order[0]]) cur = order[0];
		else                                    cur = order[3];

		if (minute >= start_min[cur]) begin
			elapsed = minute - start_min[cur];
		end else begin
			// past midnight: count from the start of the previous day
			wrapped = int'(minute) + int'(MinutesPerDay);
			elapsed = (wrapped >= start_min[cur]) ? wrapped - start_min[cur] : 0;
		end

		len = span[cur];
		res.phase = cur;
		if (len == 0) begin
			res.progress    = '0;
			res.zero_length = 1'b1;
		end else begin
			prog = (elapsed * ProgressMax) / len;
			if (prog > ProgressMax) prog = ProgressMax;
			res.progress    = prog[ProgW-1:0];
			res.zero_length = 1'b0;
		end
		return res;
	endfunction

	// Watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		phase_status_t want;
		int unsigned   fails;
		if (!arst_n) begin
			start_min = '{NightReset, SunriseReset, DayReset, SunsetReset};
			auto_on   = 1'b1;
			rebuild_schedule();
			pending_status.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			fails = 0;
			// status transaction against the oldest prediction
			if (status_valid && status_ready) begin
				if (pending_status.size() == 0) begin
					$error("unexpected status: phase %0d progress %0d zero_length %0d",
						status_phase, status_progress, status_zero);
					fails++;
				end else begin
					want = pending_status.pop_front();
					if (status_phase !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, status_phase);
						fails++;
					end
					if (status_progress !== want.progress) begin
						$error("progress: expected %0d, actual %0d", want.progress,
							status_progress);
						fails++;
					end
					if (status_zero !== want.zero_length) begin
						$error("zero_length: expected %0d, actual %0d", want.zero_length,
							status_zero);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
			// manual mode drops ticks
			if (tick_valid && tick_ready && auto_on)
				pending_status.push_back(phase_status(tick_minute));
			errors      <= errors + fails;
			outstanding <= pending_status.size();
		end
	end

endmodule

// File: tb/sv/tb_day_phase_fraction_scheduler.sv
// Testbench top for the day phase scheduler: stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module tb_day_phase_fraction_scheduler;
	import dpfs_pkg::*;

	localparam int unsigned     RandomItems    = 930;
	localparam int unsigned     HoldCycles     = 160;
	localparam int unsigned     SettleCycles   = 16;
	localparam int unsigned     CycleLimit     = 600000;
	localparam logic [MinW-1:0] MinuteMax      = '1;
	localparam logic [IdxW-1:0] FirstUnusedReg = REG_AUTO_MODE + 1'b1;
	localparam logic [IdxW-1:0] LastUnusedReg  = '1;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            pressure_go;
	bit              sender_calm;
	int unsigned     errors, outstanding;
	int unsigned     cycle_count = 0;
	logic [MinW-1:0] cur_start [PhaseCount];

	dpfs_tick_if   tick_if ();
	dpfs_status_if status_if ();
	dpfs_cfg_if    cfg_if ();

	day_phase_fraction_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.status (status_if),
		.cfg    (cfg_if)
	);

	dpfs_status_checker status_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick_valid      (tick_if.valid),
		.tick_ready      (tick_if.ready),
		.tick_minute     (tick_if.minute_of_day),
		.status_valid    (status_if.valid),
		.status_ready    (status_if.ready),
		.status_phase    (status_if.phase),
		.status_progress (status_if.progress),
		.status_zero     (status_if.zero_length),
		.cfg_valid       (cfg_if.valid),
		.cfg_ready       (cfg_if.ready),
		.cfg_index       (cfg_if.index),
		.cfg_data        (cfg_if.data),
		.errors          (errors),
		.outstanding     (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One tick transaction; returns at the accepting edge or after the idle gap that follows it
	task automatic offer_minute(input logic [MinW-1:0] minute);
		int unsigned gap;
		tick_if.minute_of_day <= minute;
		tick_if.valid         <= 1'b1;
		do @(posedge clk); while (!tick_if.ready);
		gap = sender_calm ? 0 : pick_gap();
		if (gap != 0) begin
			tick_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [MinW-1:0] value);
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_starts(input logic [MinW-1:0] night, sunrise, day, sunset);
		cur_start = '{night, sunrise, day, sunset};
		write_reg(REG_NIGHT_START, night);
		write_reg(REG_SUNRISE_START, sunrise);
		write_reg(REG_DAY_START, day);
		write_reg(REG_SUNSET_START, sunset);
	endtask

	// Stop offering, wait for every status, then let dropped ticks clear the chain
	task automatic drain();
		tick_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Status receiver: random stalls, calm stretches, one long hold-off on request
	initial begin : status_sink
		int unsigned stall, calm_left;
		bit          held;
		calm_left = 0;
		held      = 1'b0;
		status_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall = 0;
			if (pressure_go && !held) begin
				held  = 1'b1;
				stall = HoldCycles;
			end else if (calm_left != 0) begin
				calm_left--;
			end else if ($urandom_range(0, 49) == 0) begin
				calm_left = $urandom_range(20, 120);
			end else begin
				stall = pick_gap();
			end
			if (stall != 0) begin
				status_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			status_if.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int unsigned     auto_items, n, pick;
		logic [MinW-1:0] minute, value;
		bit              manual, first;
		arst_n                <= 1'b0;
		pressure_go           <= 1'b0;
		tick_if.valid         <= 1'b0;
		tick_if.minute_of_day <= '0;
		cfg_if.valid          <= 1'b0;
		cfg_if.index          <= REG_NIGHT_START;
		cfg_if.data           <= '0;
		sender_calm = 1'b0;
		cur_start   = '{NightReset, SunriseReset, DayReset, SunsetReset};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset schedule: each phase edge, end of day, out-of-range minute
		offer_minute(0);
		offer_minute(359);
		offer_minute(SunriseReset);
		offer_minute(479);
		offer_minute(DayReset);
		offer_minute(1139);
		offer_minute(SunsetReset);
		offer_minute(MinutesPerDay - 1);
		offer_minute(2000);
		drain();

		// all starts zero: night is latest, three zero lengths
		load_starts(0, 0, 0, 0);
		offer_minute(0);
		offer_minute(MinutesPerDay - 1);
		drain();

		// tie for latest start goes to the lowest phase
		load_starts(600, 600, 100, 600);
		offer_minute(700);
		offer_minute(300);
		drain();

		// start above the day wraps a length to zero
		load_starts(0, MinutesPerDay, 0, 0);
		offer_minute(1500);
		offer_minute(MinutesPerDay - 1);
		drain();

		// midnight wrap with negative elapsed, maximal start and minute
		load_starts(100, 360, 480, MinuteMax);
		offer_minute(50);
		offer_minute(MinuteMax);
		drain();

		// unused register indexes change nothing
		write_reg(FirstUnusedReg, '0);
		write_reg(FirstUnusedReg + 1'b1, MinuteMax);
		write_reg(LastUnusedReg, 1234);
		offer_minute(50);
		drain();

		// manual mode drops ticks; upper data bits of the mode are ignored
		write_reg(REG_AUTO_MODE, '0);
		offer_minute(0);
		offer_minute(MinuteMax);
		drain();
		write_reg(REG_AUTO_MODE, 3);
		offer_minute(720);
		drain();

		// random schedules, each followed by a burst of ticks
		auto_items = 0;
		first      = 1'b1;
		while (auto_items < RandomItems) begin
			for (int p = 0; p < PhaseCount; p++) begin
				if ($urandom_range(0, 3) != 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 7)
						cur_start[p] = MinW'($urandom_range(0, MinutesPerDay - 1));
					else if (pick < 9)
						cur_start[p] = cur_start[PhaseW'($urandom_range(0, PhaseCount - 1))];
					else cur_start[p] = MinW'($urandom_range(0, MinuteMax));
					write_reg(IdxW'(REG_NIGHT_START + p), cur_start[p]);
				end
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(IdxW'($urandom_range(FirstUnusedReg, LastUnusedReg)),
					MinW'($urandom_range(0, MinuteMax)));
			manual = !first && ($urandom_range(0, 5) == 0);
			value = MinW'($urandom_range(0, MinuteMax));
			value[0] = !manual;
			write_reg(REG_AUTO_MODE, value);

			// first burst runs into the long receiver hold-off
			sender_calm = first || ($urandom_range(0, 3) == 0);
			if (first) begin
				n = 80;
				pressure_go <= 1'b1;
			end else begin
				n = manual ? $urandom_range(5, 15) : $urandom_range(10, 60);
			end
			repeat (n) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) minute = MinW'($urandom_range(0, MinutesPerDay - 1));
				else if (pick < 8)
					minute = cur_start[PhaseW'($urandom_range(0, PhaseCount - 1))]
						+ MinW'($urandom_range(0, 2)) - 1'b1;
				else minute = MinW'($urandom_range(0, MinuteMax));
				offer_minute(minute);
			end
			if (!manual) auto_items += n;
			drain();
			first = 1'b0;
		end

		if (errors == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
